[rtl/bnd_pkg.sv]
// ----------------------------------------------------------------------------
// bnd_pkg: shared constants, types and tables for bearing_and_distance
// Datapath widths, the CORDIC phase table and the output scaling constants.
// ----------------------------------------------------------------------------
package bnd_pkg;

    // Number of CORDIC micro-rotations (12 to 32)
    localparam int CORDIC_STAGES = 24;

    // Coordinate and difference widths
    localparam int COORD_W = 32;
    localparam int DIFF_W  = COORD_W + 1;

    // Guard bits added below the difference LSB
    localparam int GUARD_BITS = 16;

    // CORDIC word: |diff| < 2^32, shifted by 16, grown by gain*sqrt(2) < 2.4
    localparam int WORD_W = DIFF_W + GUARD_BITS + 3;

    // Phase accumulator, 2^32 equals one full turn
    localparam int PHASE_W = 32;

    // Output widths
    localparam int BEARING_W  = 25;
    localparam int DISTANCE_W = 33;

    // Bearing scaling: phase * 360, rounded, 16 fraction bits kept
    localparam int DEG_MUL_W  = 9;
    localparam int BRG_PROD_W = PHASE_W + DEG_MUL_W;
    localparam int BRG_RND_W  = BRG_PROD_W - 16 + 1;
    localparam logic [DEG_MUL_W-1:0]  DEG_MUL  = DEG_MUL_W'(360);
    localparam logic [BRG_RND_W-1:0]  DEG_FULL = BRG_RND_W'(23592960);

    // Gain correction: round(2^32 / K)
    localparam int GAIN_W = 32;
    localparam logic [GAIN_W-1:0] INV_GAIN = 32'd2608131496;

    // Magnitude split for the gain multiply
    localparam int MAG_W    = WORD_W - 1;
    localparam int MAG_LO_W = 32;
    localparam int MAG_HI_W = MAG_W - MAG_LO_W;
    localparam int PROD_LO_W = MAG_LO_W + GAIN_W;
    localparam int PROD_HI_W = MAG_HI_W + GAIN_W;
    localparam int SUM_W     = PROD_HI_W + 1;
    localparam int DIST_FULL_W = SUM_W - GUARD_BITS + 1;
    localparam logic [DISTANCE_W-1:0] DIST_MAX = {DISTANCE_W{1'b1}};

    typedef logic signed [WORD_W-1:0]  cdc_word_t;
    typedef logic        [PHASE_W-1:0] phase_t;

    // Micro-rotation angles: round(atan(2^-i) * 2^32 / (2*pi))
    function automatic phase_t atan_phase(input int idx);
        phase_t val;
        case (idx)
            0:  val = 32'd536870912;
            1:  val = 32'd316933406;
            2:  val = 32'd167458907;
            3:  val = 32'd85004756;
            4:  val = 32'd42667331;
            5:  val = 32'd21354465;
            6:  val = 32'd10679838;
            7:  val = 32'd5340245;
            8:  val = 32'd2670163;
            9:  val = 32'd1335087;
            10: val = 32'd667544;
            11: val = 32'd333772;
            12: val = 32'd166886;
            13: val = 32'd83443;
            14: val = 32'd41722;
            15: val = 32'd20861;
            16: val = 32'd10430;
            17: val = 32'd5215;
            18: val = 32'd2608;
            19: val = 32'd1304;
            20: val = 32'd652;
            21: val = 32'd326;
            22: val = 32'd163;
            23: val = 32'd81;
            24: val = 32'd41;
            25: val = 32'd20;
            26: val = 32'd10;
            27: val = 32'd5;
            28: val = 32'd3;
            29: val = 32'd1;
            30: val = 32'd1;
            default: val = 32'd0;
        endcase
        return val;
    endfunction

endpackage

[rtl/bearing_and_distance.sv]
// ----------------------------------------------------------------------------
// bearing_and_distance: pipelined CORDIC bearing and range between two points
// Forms the coordinate differences, vectors them onto the x axis and scales
// the accumulated phase to degrees and the final x to a gain-corrected range.
// ----------------------------------------------------------------------------
// Registers from input beat to output beat: difference, pre-rotation, one
// register per micro-rotation, multiply, round, output register.
// Throughput: one beat per cycle; the whole pipeline holds while the output
// beat is not taken.
// Reset: rst_n clears all valid bits at once; payload registers are not reset.
module bearing_and_distance
    import bnd_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_W-1:0]    from_x,
    input  logic signed [COORD_W-1:0]    from_y,
    input  logic signed [COORD_W-1:0]    to_x,
    input  logic signed [COORD_W-1:0]    to_y,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic        [BEARING_W-1:0]  bearing_deg,
    output logic        [DISTANCE_W-1:0] distance
);

    // Pipeline advance: every stage moves when the output slot frees up
    logic advance;

    // Difference stage
    logic                     d_valid_reg;
    logic signed [DIFF_W-1:0] dx_reg;
    logic signed [DIFF_W-1:0] dy_reg;
    logic signed [DIFF_W-1:0] dx_next;
    logic signed [DIFF_W-1:0] dy_next;

    // CORDIC stages: index 0 is after pre-rotation, index k after k rotations
    logic      [CORDIC_STAGES:0] c_valid_reg;
    logic      [CORDIC_STAGES:0] c_zero_reg;
    cdc_word_t                   x_reg  [0:CORDIC_STAGES];
    cdc_word_t                   y_reg  [0:CORDIC_STAGES];
    phase_t                      ph_reg [0:CORDIC_STAGES];
    cdc_word_t                   x_next [0:CORDIC_STAGES];
    cdc_word_t                   y_next [0:CORDIC_STAGES];
    phase_t                      ph_next[0:CORDIC_STAGES];
    logic                        zero_next;

    // Multiply stage
    logic                    m_valid_reg;
    logic                    m_zero_reg;
    logic [BRG_PROD_W-1:0]   brg_prod_reg;
    logic [PROD_LO_W-1:0]    prod_lo_reg;
    logic [PROD_HI_W-1:0]    prod_hi_reg;
    logic [BRG_PROD_W-1:0]   brg_prod_next;
    logic [PROD_LO_W-1:0]    prod_lo_next;
    logic [PROD_HI_W-1:0]    prod_hi_next;
    logic [MAG_W-1:0]        mag;

    // Rounding stage
    logic                    s_valid_reg;
    logic                    s_zero_reg;
    logic [BRG_RND_W-1:0]    brg_rnd_reg;
    logic [DIST_FULL_W-1:0]  dist_full_reg;
    logic [BRG_RND_W-1:0]    brg_rnd_next;
    logic [DIST_FULL_W-1:0]  dist_full_next;
    logic [SUM_W-1:0]        gain_sum;

    // Output stage
    logic                    out_valid_reg;
    logic [BEARING_W-1:0]    bearing_deg_reg;
    logic [DISTANCE_W-1:0]   distance_reg;
    logic [BEARING_W-1:0]    bearing_deg_next;
    logic [DISTANCE_W-1:0]   distance_next;

    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = advance;
    assign out_valid = out_valid_reg;
    assign bearing_deg = bearing_deg_reg;
    assign distance    = distance_reg;

    // Form exact 33-bit differences
    assign dx_next = DIFF_W'(to_x) - DIFF_W'(from_x);
    assign dy_next = DIFF_W'(to_y) - DIFF_W'(from_y);

    // Pre-rotate into the right half plane and add guard bits, then
    // drive y toward zero, one micro-rotation per stage
    always_comb
    begin
        cdc_word_t xs;
        cdc_word_t ys;
        xs = WORD_W'(dx_reg) <<< GUARD_BITS;
        ys = WORD_W'(dy_reg) <<< GUARD_BITS;
        zero_next = (dx_reg == '0) && (dy_reg == '0);
        if (dx_reg[DIFF_W-1])
        begin
            x_next[0]  = -xs;
            y_next[0]  = -ys;
            ph_next[0] = {1'b1, {(PHASE_W-1){1'b0}}};
        end
        else
        begin
            x_next[0]  = xs;
            y_next[0]  = ys;
            ph_next[0] = '0;
        end
        for (int k = 0; k < CORDIC_STAGES; k++)
        begin
            if (!y_reg[k][WORD_W-1])
            begin
                x_next[k+1]  = x_reg[k] + (y_reg[k] >>> k);
                y_next[k+1]  = y_reg[k] - (x_reg[k] >>> k);
                ph_next[k+1] = ph_reg[k] + atan_phase(k);
            end
            else
            begin
                x_next[k+1]  = x_reg[k] - (y_reg[k] >>> k);
                y_next[k+1]  = y_reg[k] + (x_reg[k] >>> k);
                ph_next[k+1] = ph_reg[k] - atan_phase(k);
            end
        end
    end

    // Scale phase to degrees and split the gain multiply
    always_comb
    begin
        cdc_word_t xf;
        xf  = x_reg[CORDIC_STAGES];
        mag = xf[WORD_W-1] ? '0 : xf[MAG_W-1:0];
        brg_prod_next = BRG_PROD_W'(ph_reg[CORDIC_STAGES]) * BRG_PROD_W'(DEG_MUL);
        prod_lo_next  = PROD_LO_W'(mag[MAG_LO_W-1:0]) * PROD_LO_W'(INV_GAIN);
        prod_hi_next  = PROD_HI_W'(mag[MAG_W-1:MAG_LO_W]) * PROD_HI_W'(INV_GAIN);
    end

    // Round bearing and distance, wrap a full turn to zero
    always_comb
    begin
        logic [BRG_RND_W-1:0] brg_tmp;
        brg_tmp = BRG_RND_W'((BRG_PROD_W'(brg_prod_reg) + BRG_PROD_W'(32768)) >> 16);
        brg_rnd_next = (brg_tmp >= DEG_FULL) ? '0 : brg_tmp;
        gain_sum = SUM_W'(prod_hi_reg) + SUM_W'(prod_lo_reg[PROD_LO_W-1:MAG_LO_W]);
        dist_full_next = DIST_FULL_W'((gain_sum + SUM_W'(32768)) >> GUARD_BITS);
    end

    // Saturate distance and force zero for equal points
    always_comb
    begin
        if (s_zero_reg)
        begin
            bearing_deg_next = '0;
            distance_next    = '0;
        end
        else
        begin
            bearing_deg_next = brg_rnd_reg[BEARING_W-1:0];
            if (dist_full_reg > DIST_FULL_W'(DIST_MAX))
                distance_next = DIST_MAX;
            else
                distance_next = dist_full_reg[DISTANCE_W-1:0];
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg   <= 1'b0;
            c_valid_reg   <= '0;
            m_valid_reg   <= 1'b0;
            s_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            d_valid_reg   <= in_valid;
            c_valid_reg   <= {c_valid_reg[CORDIC_STAGES-1:0], d_valid_reg};
            m_valid_reg   <= c_valid_reg[CORDIC_STAGES];
            s_valid_reg   <= m_valid_reg;
            out_valid_reg <= s_valid_reg;
        end
    end

    // Advance payload; hold everything while stalled
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
            c_zero_reg <= {c_zero_reg[CORDIC_STAGES-1:0], zero_next};
            for (int k = 0; k <= CORDIC_STAGES; k++)
            begin
                x_reg[k]  <= x_next[k];
                y_reg[k]  <= y_next[k];
                ph_reg[k] <= ph_next[k];
            end
            m_zero_reg      <= c_zero_reg[CORDIC_STAGES];
            brg_prod_reg    <= brg_prod_next;
            prod_lo_reg     <= prod_lo_next;
            prod_hi_reg     <= prod_hi_next;
            s_zero_reg      <= m_zero_reg;
            brg_rnd_reg     <= brg_rnd_next;
            dist_full_reg   <= dist_full_next;
            bearing_deg_reg <= bearing_deg_next;
            distance_reg    <= distance_next;
        end
    end

    // Bearing always lies below a full turn
    a_bearing_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (BRG_RND_W'(bearing_deg) < DEG_FULL))
        else $error("bearing at or above 360 degrees");

    // Vectoring never leaves a negative magnitude
    a_mag_positive: assert property (@(posedge clk) disable iff (!rst_n)
        c_valid_reg[CORDIC_STAGES] |-> !x_reg[CORDIC_STAGES][WORD_W-1])
        else $error("negative CORDIC magnitude");

    // A stalled output beat keeps its results
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(bearing_deg)
            && $stable(distance)))
        else $error("stalled output changed");

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for bearing_and_distance
// Drives start/target point pairs through the valid/ready input, predicts
// bearing and range with a bit-exact CORDIC model and checks every output
// beat in order, under random source bursts and random sink stalls.
// ----------------------------------------------------------------------------
module tb
    import bnd_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 4000;
    localparam int RANDOM_BEATS = 1630;

    localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;

    // Full turn in Q16 degrees and round(2^32 / K)
    localparam longint unsigned TURN_Q16   = 64'd23592960;
    localparam longint unsigned RANGE_GAIN = 64'd2608131496;
    localparam longint unsigned RANGE_SAT  = 64'h1_FFFF_FFFF;

    // Micro-rotation angles, 2^32 per turn
    localparam bit [31:0] ROT_ANGLE [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef struct packed {
        logic [BEARING_W-1:0]  bearing;
        logic [DISTANCE_W-1:0] span;
    } fix_t;

    // Predict bearing/range per accepted point pair and match output beats
    class fix_scoreboard;
        fix_t pending_fixes[$];
        int   miss_count;

        function new();
            miss_count = 0;
        endfunction

        function fix_t compute_fix(input logic signed [COORD_W-1:0] fx, fy, tx, ty);
            longint dx, dy, x, y, xs, ys;
            bit [31:0] phase;
            longint unsigned brg, mag, t, hi, span;
            int n, i;
            fix_t r;
            dx = longint'(tx) - longint'(fx);
            dy = longint'(ty) - longint'(fy);
            r = '0;
            if (dx == 0 && dy == 0)
            begin
                return r;
            end
            x = dx * 65536;
            y = dy * 65536;
            phase = 32'd0;
            // fold the left half-plane onto the right one
            if (x < 0)
            begin
                x = -x;
                y = -y;
                phase = 32'h8000_0000;
            end
            n = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
            for (i = 0; i < n; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0)
                begin
                    x = x + ys;
                    y = y - xs;
                    phase = phase + ROT_ANGLE[i];
                end
                else
                begin
                    x = x - ys;
                    y = y + xs;
                    phase = phase - ROT_ANGLE[i];
                end
            end
            // scale phase to Q16 degrees, wrap a rounded full turn to zero
            brg = ({32'd0, phase} * 64'd360 + 64'd32768) >> 16;
            if (brg >= TURN_Q16)
            begin
                brg = 64'd0;
            end
            // correct the CORDIC gain, drop guard bits, saturate
            mag = (x < 0) ? 64'd0 : unsigned'(x);
            t = (mag & 64'hFFFF_FFFF) * RANGE_GAIN;
            hi = (mag >> 32) * RANGE_GAIN + (t >> 32);
            span = (hi + 64'd32768) >> 16;
            if (span > RANGE_SAT)
            begin
                span = RANGE_SAT;
            end
            r.bearing = brg[BEARING_W-1:0];
            r.span = span[DISTANCE_W-1:0];
            return r;
        endfunction

        function void note_points(input logic signed [COORD_W-1:0] fx, fy, tx, ty);
            pending_fixes = {pending_fixes, compute_fix(fx, fy, tx, ty)};
        endfunction

        function void check_fix(input logic [BEARING_W-1:0] brg,
                                input logic [DISTANCE_W-1:0] span);
            fix_t want;
            if (pending_fixes.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, got bearing %0d distance %0d",
                         $realtime, brg, span);
                miss_count++;
                return;
            end
            want = pending_fixes.pop_front();
            if (brg !== want.bearing)
            begin
                $display("%0t: bearing_deg expected %0d got %0d",
                         $realtime, want.bearing, brg);
                miss_count++;
            end
            if (span !== want.span)
            begin
                $display("%0t: distance expected %0d got %0d",
                         $realtime, want.span, span);
                miss_count++;
            end
        endfunction

        function int pending();
            return pending_fixes.size();
        endfunction
    endclass

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic signed [COORD_W-1:0]    from_x = '0;
    logic signed [COORD_W-1:0]    from_y = '0;
    logic signed [COORD_W-1:0]    to_x = '0;
    logic signed [COORD_W-1:0]    to_y = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic        [BEARING_W-1:0]  bearing_deg;
    logic        [DISTANCE_W-1:0] distance;

    fix_scoreboard sb = new();
    int burst_left = 0;

    bearing_and_distance uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .from_x      (from_x),
        .from_y      (from_y),
        .to_x        (to_x),
        .to_y        (to_y),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .bearing_deg (bearing_deg),
        .distance    (distance)
    );

    // Generate the 10 ns clock
    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Watch both channels at each edge: note input beats, check output beats
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                sb.note_points(from_x, from_y, to_x, to_y);
            end
            if (out_valid && out_ready)
            begin
                sb.check_fix(bearing_deg, distance);
            end
        end
    end

    // Stall the sink in segments of its own pattern
    always @(posedge clk)
    begin : sink_pace
        int sink_left;
        int sink_mode;
        if (sink_left <= 0)
        begin
            sink_mode = $urandom_range(0, 3);
            sink_left = (sink_mode == 3) ? $urandom_range(1, 15) : $urandom_range(8, 200);
        end
        sink_left--;
        case (sink_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            2:       out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= 1'b0;
        endcase
    end

    // End the run when no beat moves for too long
    initial
    begin : watchdog
        int idle_cnt;
        idle_cnt = 0;
        while (idle_cnt < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                idle_cnt = 0;
            end
            else
            begin
                idle_cnt++;
            end
        end
        $display("Simulation FAILED");
        $finish;
    end

    // Close a burst now and then: drop valid for a random gap
    task automatic pace_source();
        int gap;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Present one point pair and hold it until the beat is taken
    task automatic send_points(input logic signed [COORD_W-1:0] ax, ay, bx, by);
        in_valid <= 1'b1;
        from_x <= ax;
        from_y <= ay;
        to_x <= bx;
        to_y <= by;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        pace_source();
    endtask

    // Random offset of random bit length and sign
    function automatic logic signed [COORD_W-1:0] rand_offset();
        logic signed [COORD_W-1:0] v;
        v = $urandom >> $urandom_range(0, 31);
        return ($urandom_range(0, 1) == 1) ? -v : v;
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_corner();
        case ($urandom_range(0, 5))
            0:       return C_MAX;
            1:       return C_MIN;
            2:       return '0;
            3:       return -1;
            4:       return 1;
            default: return $urandom;
        endcase
    endfunction

    // Pick a pair from a mix of shapes: wide, near, equal, on-axis, corner, diagonal
    task automatic send_random_points();
        logic signed [COORD_W-1:0] ax, ay, bx, by, d;
        int pick;
        pick = $urandom_range(0, 99);
        ax = $urandom;
        ay = $urandom;
        bx = $urandom;
        by = $urandom;
        if (pick < 30)
        begin
            // keep the fully random pair
        end
        else if (pick < 55)
        begin
            bx = ax + rand_offset();
            by = ay + rand_offset();
        end
        else if (pick < 60)
        begin
            bx = ax;
            by = ay;
        end
        else if (pick < 72)
        begin
            if ($urandom_range(0, 1) == 1)
            begin
                bx = ax;
            end
            else
            begin
                by = ay;
            end
        end
        else if (pick < 87)
        begin
            ax = rand_corner();
            ay = rand_corner();
            bx = rand_corner();
            by = rand_corner();
        end
        else
        begin
            d = rand_offset();
            bx = ax + d;
            by = ($urandom_range(0, 1) == 1) ? ay + d : ay - d;
        end
        send_points(ax, ay, bx, by);
    endtask

    initial
    begin : stimulus
        int n;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // equal points
        send_points(0, 0, 0, 0);
        send_points(1234, -5678, 1234, -5678);
        send_points(C_MIN, C_MAX, C_MIN, C_MAX);
        send_points(C_MAX, C_MAX, C_MAX, C_MAX);
        // unit steps along each axis
        send_points(0, 0, 1, 0);
        send_points(0, 0, 0, 1);
        send_points(0, 0, -1, 0);
        send_points(0, 0, 0, -1);
        // diagonals
        send_points(-1, -1, 0, 0);
        send_points(0, 0, -1, -1);
        send_points(0, 0, 1, -1);
        send_points(0, 0, -1, 1);
        // largest differences
        send_points(C_MIN, C_MIN, C_MAX, C_MAX);
        send_points(C_MAX, C_MAX, C_MIN, C_MIN);
        send_points(C_MIN, 0, C_MAX, 0);
        send_points(C_MAX, 0, C_MIN, 0);
        send_points(0, C_MAX, 0, C_MIN);
        send_points(0, C_MIN, 0, C_MAX);
        send_points(C_MIN, C_MAX, C_MAX, C_MIN);
        // bearing just under a full turn rounds to zero
        send_points(C_MIN, 1, C_MAX, 0);
        send_points(0, 1, C_MAX, 0);
        // near due west, from either side
        send_points(0, 0, C_MIN, 1);
        send_points(0, 0, C_MIN, -1);

        for (n = 0; n < RANDOM_BEATS; n++)
        begin
            send_random_points();
        end
        in_valid <= 1'b0;

        // drain the pipeline, then watch for stray beats
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (CORDIC_STAGES + 20) @(posedge clk);

        if (sb.miss_count == 0 && sb.pending() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
